[hw/rtl/per_channel_ema_severity_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the per-channel EMA severity block
// Short forms for concurrent checks clocked on clk, with and without a
// reset guard.
// ----------------------------------------------------------------------------
`ifndef PER_CHANNEL_EMA_SEVERITY_MACROS_SVH
`define PER_CHANNEL_EMA_SEVERITY_MACROS_SVH

// Concurrent check, held off while rst is high
`define PCES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also covers the reset cycles
`define PCES_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/pces_pkg.sv]
// ----------------------------------------------------------------------------
// pces_pkg
// Shared widths, register codes, reset values and types of the per-channel
// EMA severity block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pces_pkg;

  // Field widths
  localparam int CH_W       = 6;
  localparam int CH_CODES   = 2 ** CH_W;
  localparam int RATIO_W    = 16;
  localparam int ALPHA_W    = 13;
  localparam int SEV_W      = 2;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Widest saturated alpha (fraction bits up to 16, plus one integer bit)
  localparam int WIDE_W = 17;

  // Queue between the front and the back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 13'd1229;
  localparam logic [RATIO_W-1:0] THRESH_RST = 16'd410;
  localparam logic [RATIO_W-1:0] YELLOW_RST = 16'd4915;
  localparam logic [RATIO_W-1:0] RED_RST    = 16'd8192;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA  = 4'd0,
    REG_THRESH = 4'd1,
    REG_YELLOW = 4'd2,
    REG_RED    = 4'd3
  } cfg_reg_t;

  // Severity classes
  typedef enum logic [SEV_W-1:0] {
    SEV_LIGHT    = 2'd0,
    SEV_MODERATE = 2'd1,
    SEV_HEAVY    = 2'd2
  } sev_t;

  // Sample payload carried through the queue
  typedef struct packed {
    logic               batch_end;
    logic [RATIO_W-1:0] raw_ratio;
  } item_t;

  // Control from the back to the front
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

[hw/rtl/per_channel_ema_severity.sv]
// An accepted input transaction passes through the input queue, the read stage and
// the flag stage before its result is loaded into the output register. Throughput:
// one transaction per cycle while the output does not stall; the read-modify-write
// loop through the smoothed-value memory closes by forwarding the last value written.
// Reset: synchronous; after rst falls the seen-bit memory is cleared one entry at a
// time, with s_axis_tready low meanwhile. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
// per_channel_ema_severity
// Per-channel exponential moving average with change, severity and batch
// change flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_channel_ema_severity
  import pces_pkg::*;
#(
  parameter int CHANNELS  = 64,
  parameter int FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // channel[5:0], raw_ratio[21:6]
  input  logic                  s_axis_tlast,   // batch_end
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // smoothed_ratio[15:0], severity[17:16],
                                                // changed[18], batch_changed[19]
  output logic                  m_axis_tlast,   // last
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW    = $clog2(CHANNELS);
  localparam int OUT_W = RATIO_W + SEV_W + 2;

  logic               q_valid;
  logic [IW-1:0]      q_idx;
  item_t              q_item;
  item_t              in_item;
  back_ctl_t          ctl;
  logic [RATIO_W-1:0] out_smoothed;
  logic [SEV_W-1:0]   out_severity;
  logic               out_changed;
  logic               out_batch_changed;

  // Unpack the input transaction
  assign in_item.raw_ratio = s_axis_tdata[CH_W +: RATIO_W];
  assign in_item.batch_end = s_axis_tlast;

  // Registers accept a write in every cycle
  assign cfg_ready = 1'b1;

  pces_front #(
    .CHANNELS (CHANNELS),
    .IW       (IW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_channel (s_axis_tdata[CH_W-1:0]),
    .in_item    (in_item),
    .q_valid    (q_valid),
    .q_idx      (q_idx),
    .q_item     (q_item),
    .ctl        (ctl)
  );

  pces_back #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS),
    .IW        (IW)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_valid           (q_valid),
    .q_idx             (q_idx),
    .q_item            (q_item),
    .ctl               (ctl),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .out_smoothed      (out_smoothed),
    .out_severity      (out_severity),
    .out_changed       (out_changed),
    .out_batch_changed (out_batch_changed),
    .out_last          (m_axis_tlast)
  );

  // Pack the result transaction
  assign m_axis_tdata = {{(M_TDATA_W - OUT_W){1'b0}}, out_batch_changed, out_changed,
                         out_severity, out_smoothed};

endmodule

[hw/rtl/pces_front.sv]
// ----------------------------------------------------------------------------
// pces_front
// Accepts samples, folds the channel number into the table range and queues
// them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pces_front
  import pces_pkg::*;
#(
  parameter int CHANNELS = 64,
  parameter int IW       = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [CH_W-1:0] in_channel,
  input  item_t           in_item,
  output logic            q_valid,
  output logic [IW-1:0]   q_idx,
  output item_t           q_item,
  input  back_ctl_t       ctl
);

  logic [IW-1:0]     wrap_tab [CH_CODES];
  logic [IW-1:0]     q_idx_mem [QDEPTH];
  item_t             q_item_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  // Wrap channel codes beyond the table onto it
  for (genvar g = 0; g < CH_CODES; g++) begin : g_wrap
    assign wrap_tab[g] = IW'(g % CHANNELS);
  end

  // Hold off input while the queue is full or the seen bits are being cleared
  assign in_ready = !ctl.clearing && (count != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_idx    = q_idx_mem[rd_ptr];
  assign q_item   = q_item_mem[rd_ptr];

  // Advance queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (ctl.pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, ctl.pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Store the transaction payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_idx_mem[wr_ptr]  <= wrap_tab[in_channel];
      q_item_mem[wr_ptr] <= in_item;
    end
  end

endmodule

[hw/rtl/pces_back.sv]
// ----------------------------------------------------------------------------
// pces_back
// Per-channel smoothing with the value and seen-bit memories, change and
// severity flags, batch flag and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pces_back
  import pces_pkg::*;
#(
  parameter int CHANNELS  = 64,
  parameter int FRAC_BITS = 12,
  parameter int IW        = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_valid,
  input  logic [IW-1:0]         q_idx,
  input  item_t                 q_item,
  output back_ctl_t             ctl,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RATIO_W-1:0]    out_smoothed,
  output logic [SEV_W-1:0]      out_severity,
  output logic                  out_changed,
  output logic                  out_batch_changed,
  output logic                  out_last
);

  localparam int AW = FRAC_BITS + 1;
  localparam int PW = AW + RATIO_W;
  localparam int SW = PW + 1;
  localparam logic [WIDE_W-1:0] ONE_WIDE = WIDE_W'(1) << FRAC_BITS;
  localparam logic [AW-1:0] ALPHA_RST_SAT =
    (WIDE_W'(ALPHA_RST) > ONE_WIDE) ? AW'(ONE_WIDE) : AW'(ALPHA_RST);
  localparam logic [AW-1:0] BETA_RST = AW'(ONE_WIDE) - ALPHA_RST_SAT;

  // Configuration
  logic [AW-1:0]      alpha_sat;
  logic [AW-1:0]      beta;
  logic [RATIO_W-1:0] threshold;
  logic [RATIO_W-1:0] yellow_level;
  logic [RATIO_W-1:0] red_level;
  logic [WIDE_W-1:0]  alpha_in;
  logic [WIDE_W-1:0]  alpha_cap;

  // Clearing pass
  logic          clearing;
  logic [IW-1:0] clear_idx;

  // Memories
  logic [RATIO_W-1:0] sm_mem [CHANNELS];
  logic               seen_mem [CHANNELS];
  logic [RATIO_W-1:0] rd_sm;
  logic               rd_seen;
  logic               seen_we;
  logic [IW-1:0]      seen_waddr;

  // Pipeline control
  logic adv;
  logic pop;
  logic s2_fire;
  logic s3_fire;

  // Read stage
  logic               s2_valid;
  logic [IW-1:0]      s2_idx;
  logic [RATIO_W-1:0] s2_raw;
  logic               s2_bend;
  logic [PW-1:0]      s2_araw;
  logic               fwd;
  logic [RATIO_W-1:0] prev;
  logic               seen;
  logic [PW-1:0]      bprev;
  logic [SW-1:0]      sum;
  logic [SW-1:0]      shifted;
  logic [RATIO_W-1:0] sm_calc;
  logic [RATIO_W-1:0] sm_next;

  // Flag stage
  logic               s3_valid;
  logic [IW-1:0]      s3_idx;
  logic [RATIO_W-1:0] s3_sm;
  logic [RATIO_W-1:0] s3_raw;
  logic               s3_bend;
  logic [RATIO_W-1:0] diff;
  logic               chg;
  logic               bchg;
  sev_t               sev;
  logic               batch_flag;

  // Saturate alpha at one on write
  assign alpha_in  = WIDE_W'(cfg_data[ALPHA_W-1:0]);
  assign alpha_cap = (alpha_in > ONE_WIDE) ? ONE_WIDE : alpha_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_sat    <= ALPHA_RST_SAT;
      beta         <= BETA_RST;
      threshold    <= THRESH_RST;
      yellow_level <= YELLOW_RST;
      red_level    <= RED_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ALPHA: begin
          alpha_sat <= AW'(alpha_cap);
          beta      <= AW'(ONE_WIDE - alpha_cap);
        end
        REG_THRESH: threshold    <= cfg_data[RATIO_W-1:0];
        REG_YELLOW: yellow_level <= cfg_data[RATIO_W-1:0];
        REG_RED:    red_level    <= cfg_data[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sweep the seen bits to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_idx <= '0;
    end else if (clearing) begin
      clear_idx <= clear_idx + IW'(1);
      if (clear_idx == IW'(CHANNELS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Advance the whole pipeline together when the output register frees up
  assign adv     = !out_valid || out_ready;
  assign pop     = adv && q_valid && !clearing;
  assign s2_fire = adv && s2_valid;
  assign s3_fire = adv && s3_valid;
  assign ctl.pop      = pop;
  assign ctl.clearing = clearing;

  // Smoothed-value memory: write from the read stage, registered read on pop
  always_ff @(posedge clk) begin
    if (s2_fire) begin
      sm_mem[s2_idx] <= sm_next;
    end
    if (pop) begin
      rd_sm <= sm_mem[q_idx];
    end
  end

  // Seen-bit memory: shared write port for the clearing pass and updates
  assign seen_we    = clearing || s2_fire;
  assign seen_waddr = clearing ? clear_idx : s2_idx;

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_waddr] <= !clearing;
    end
    if (pop) begin
      rd_seen <= seen_mem[q_idx];
    end
  end

  // Load the read stage and form the new-sample product
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_idx  <= q_idx;
      s2_raw  <= q_item.raw_ratio;
      s2_bend <= q_item.batch_end;
      s2_araw <= PW'(alpha_sat) * PW'(q_item.raw_ratio);
    end
  end

  // Forward the value just written when the same channel follows directly
  assign fwd  = s3_valid && (s3_idx == s2_idx);
  assign prev = fwd ? s3_sm : rd_sm;
  assign seen = fwd || rd_seen;

  // Blend with the previous value, truncate and clamp; a channel's first sample passes through
  assign bprev   = PW'(beta) * PW'(prev);
  assign sum     = SW'(s2_araw) + SW'(bprev);
  assign shifted = sum >> FRAC_BITS;
  assign sm_calc = (|shifted[SW-1:RATIO_W]) ? '1 : shifted[RATIO_W-1:0];
  assign sm_next = seen ? sm_calc : s2_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      s3_idx  <= s2_idx;
      s3_sm   <= sm_next;
      s3_raw  <= s2_raw;
      s3_bend <= s2_bend;
    end
  end

  // Classify the smoothed value and flag a change from the raw sample
  assign diff = (s3_sm >= s3_raw) ? (s3_sm - s3_raw) : (s3_raw - s3_sm);
  assign chg  = (diff > threshold);
  assign bchg = batch_flag || chg;

  always_comb begin
    if (s3_sm < yellow_level) begin
      sev = SEV_LIGHT;
    end else if (s3_sm < red_level) begin
      sev = SEV_MODERATE;
    end else begin
      sev = SEV_HEAVY;
    end
  end

  // Track the batch flag and load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      batch_flag <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_valid;
      if (s3_valid) begin
        batch_flag <= s3_bend ? 1'b0 : bchg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_fire) begin
      out_smoothed      <= s3_sm;
      out_severity      <= sev;
      out_changed       <= chg;
      out_batch_changed <= bchg;
      out_last          <= s3_bend;
    end
  end

endmodule

[hw/rtl/pces_checker.sv]
// ----------------------------------------------------------------------------
// pces_checker
// Port-level checks of the per-channel EMA severity block, bound to the top
// level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "per_channel_ema_severity_macros.svh"

module pces_checker
  import pces_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  localparam int SEV_LSB  = RATIO_W;
  localparam int CHG_BIT  = RATIO_W + SEV_W;
  localparam int BCHG_BIT = CHG_BIT + 1;

  // After reset no result is shown and input waits for the clearing pass
  `PCES_ASSERT_RST(a_reset_quiet, rst |=> !s_axis_tready && !m_axis_tvalid, "output or input active after reset")

  // A stalled result keeps its contents
  `PCES_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // Severity uses only the three defined classes
  `PCES_ASSERT(a_sev_range, m_axis_tvalid |-> m_axis_tdata[SEV_LSB +: SEV_W] <= SEV_HEAVY, "severity out of range")

  // A changed sample always marks its batch as changed
  `PCES_ASSERT(a_batch_or, m_axis_tvalid && m_axis_tdata[CHG_BIT] |-> m_axis_tdata[BCHG_BIT], "batch flag misses a change")

endmodule

bind per_channel_ema_severity pces_checker u_pces_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[test/per_channel_ema_severity_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_channel_ema_severity_tb
// Self-checking bench for the per-channel EMA severity block. Samples are
// streamed in with random gaps while the output side stalls at random. A
// behavioral EMA tracks every channel and predicts the smoothed value,
// severity class, change flag and batch change flag of each result. Register
// settings change between phases, the extremes among them.
// ----------------------------------------------------------------------------

module per_channel_ema_severity_tb;
  import pces_pkg::*;

  localparam int CHANNELS       = 64;
  localparam int FRAC_BITS      = 12;
  localparam int UNITY          = 1 << FRAC_BITS;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_SAMPLES  = 80;
  localparam int LONG_HOLD      = 100;
  localparam int HOLD_SPACING   = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 40;

  // First register index that maps to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd4;

  typedef struct {
    logic [CH_W-1:0]    channel;
    logic [RATIO_W-1:0] raw;
    logic               batch_end;
  } sample_t;

  typedef struct {
    logic [RATIO_W-1:0] smoothed;
    sev_t               severity;
    logic               changed;
    logic               batch_changed;
    logic               last;
  } ema_result_t;

  // DUT signals, known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ALPHA;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies held by the predictor
  logic [ALPHA_W-1:0] cfg_alpha  = ALPHA_RST;
  logic [RATIO_W-1:0] cfg_thresh = THRESH_RST;
  logic [RATIO_W-1:0] cfg_yellow = YELLOW_RST;
  logic [RATIO_W-1:0] cfg_red    = RED_RST;

  // Per-channel EMA state mirrored from the block
  logic [RATIO_W-1:0] ema_value [CHANNELS];
  logic               ema_seen  [CHANNELS];
  logic               batch_acc = 1'b0;

  sample_t     sample_q[$];
  ema_result_t pending_results[$];
  sample_t     cur_sample;
  ema_result_t head_result;

  int unsigned samples_queued  = 0;
  int unsigned samples_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned cfg_writes      = 0;
  int unsigned long_holds      = 0;
  int unsigned send_gap        = 0;
  int unsigned hold_left       = 0;
  int unsigned next_hold_at    = 150;
  bit          sender_idles    = 1'b0;
  bit          sink_stalls     = 1'b0;

  per_channel_ema_severity #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      ema_value[i] = '0;
      ema_seen[i]  = 1'b0;
    end
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Advance the channel EMA for one accepted sample and queue its result
  task automatic ema_predict(input sample_t s);
    int unsigned a;
    int unsigned sm;
    int unsigned dev;
    ema_result_t r;
    a = (32'(cfg_alpha) > UNITY) ? UNITY : 32'(cfg_alpha);
    if (!ema_seen[s.channel]) begin
      sm = 32'(s.raw);
      ema_seen[s.channel] = 1'b1;
    end else begin
      sm = (a * 32'(s.raw) + (UNITY - a) * 32'(ema_value[s.channel])) >> FRAC_BITS;
      if (sm > 16'hFFFF) sm = 16'hFFFF;
    end
    ema_value[s.channel] = sm[RATIO_W-1:0];
    dev = (sm >= 32'(s.raw)) ? sm - 32'(s.raw) : 32'(s.raw) - sm;
    r.smoothed = sm[RATIO_W-1:0];
    r.changed  = (dev > 32'(cfg_thresh));
    if (sm < 32'(cfg_yellow)) r.severity = SEV_LIGHT;
    else if (sm < 32'(cfg_red)) r.severity = SEV_MODERATE;
    else r.severity = SEV_HEAVY;
    r.batch_changed = batch_acc | r.changed;
    r.last = s.batch_end;
    batch_acc = s.batch_end ? 1'b0 : r.batch_changed;
    pending_results = {pending_results, r};
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    // Keep the log short on a badly broken build
    if (mismatches <= MAX_PRINTS)
      $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
               results_checked, what, got, want);
  endtask

  // Sender: present queued samples, predict on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        ema_predict(cur_sample);
        samples_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          cur_sample = sample_q.pop_front();
          s_axis_tdata  <= {2'b00, cur_sample.raw, cur_sample.channel};
          s_axis_tlast  <= cur_sample.batch_end;
          s_axis_tvalid <= 1'b1;
          send_gap = sender_idles ? gap_len() : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transaction, then decide on stalling
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(m_axis_tdata), 0);
        end else begin
          head_result = pending_results.pop_front();
          if (m_axis_tdata[15:0] != head_result.smoothed)
            report_mismatch("smoothed_ratio", m_axis_tdata[15:0], head_result.smoothed);
          if (m_axis_tdata[17:16] != head_result.severity)
            report_mismatch("severity", m_axis_tdata[17:16], head_result.severity);
          if (m_axis_tdata[18] != head_result.changed)
            report_mismatch("changed", m_axis_tdata[18], head_result.changed);
          if (m_axis_tdata[19] != head_result.batch_changed)
            report_mismatch("batch_changed", m_axis_tdata[19], head_result.batch_changed);
          if (m_axis_tlast != head_result.last)
            report_mismatch("last", m_axis_tlast, head_result.last);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (results_checked >= next_hold_at) begin
        // Long hold so the block fills up and backs off its input
        next_hold_at += HOLD_SPACING;
        hold_left = LONG_HOLD - 1;
        long_holds++;
        m_axis_tready <= 1'b0;
      end else begin
        hold_left = sink_stalls ? gap_len() : 0;
        if (hold_left > 0) begin
          hold_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("per_channel_ema_severity verification failed");
    $finish;
  end

  task automatic queue_sample(input logic [CH_W-1:0] ch, input logic [RATIO_W-1:0] raw,
                              input logic bend);
    sample_t s;
    s.channel   = ch;
    s.raw       = raw;
    s.batch_end = bend;
    sample_q = {sample_q, s};
    samples_queued++;
  endtask

  // Wait until every queued sample has come back as a result
  task automatic drain();
    while (results_checked < samples_queued) @(posedge clk);
  endtask

  // One register write transaction; update the predictor copy when taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ALPHA:  cfg_alpha  = val[ALPHA_W-1:0];
      REG_THRESH: cfg_thresh = val;
      REG_YELLOW: cfg_yellow = val;
      REG_RED:    cfg_red    = val;
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  initial begin : main
    logic [RATIO_W-1:0] yl;
    logic [RATIO_W-1:0] rl;
    logic [RATIO_W-1:0] raw;
    logic [CH_W-1:0]    ch_base;
    logic [CH_W-1:0]    ch;
    int unsigned        ch_span;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first-sample pass-through, level edges, batch flag
    queue_sample(6'd0, 16'd0, 1'b0);
    queue_sample(6'd0, 16'hFFFF, 1'b0);
    queue_sample(6'd0, 16'hFFFF, 1'b0);
    queue_sample(6'd63, 16'hFFFF, 1'b1);
    queue_sample(6'd10, 16'd4914, 1'b0);
    queue_sample(6'd11, 16'd4915, 1'b0);
    queue_sample(6'd12, 16'd8191, 1'b0);
    queue_sample(6'd13, 16'd8192, 1'b1);
    queue_sample(6'd63, 16'd0, 1'b0);
    queue_sample(6'd10, 16'd4914, 1'b1);
    queue_sample(6'd10, 16'd4914, 1'b0);
    drain();

    // Frozen average, tight threshold, yellow level above red level
    write_reg(REG_ALPHA, 16'd0);
    write_reg(REG_THRESH, 16'd100);
    write_reg(REG_YELLOW, 16'd9000);
    write_reg(REG_RED, 16'd5000);
    write_reg(REG_SPARE_LO, 16'd0);
    queue_sample(6'd20, 16'd6000, 1'b0);
    queue_sample(6'd20, 16'd6100, 1'b0);
    queue_sample(6'd20, 16'd6101, 1'b0);
    queue_sample(6'd20, 16'd5899, 1'b1);
    queue_sample(6'd21, 16'd9500, 1'b0);
    queue_sample(6'd22, 16'd4000, 1'b0);
    drain();

    // Alpha written above one saturates; zero threshold and zero yellow level
    write_reg(REG_ALPHA, 16'hFFFF);
    write_reg(REG_THRESH, 16'd0);
    write_reg(REG_YELLOW, 16'd0);
    write_reg(REG_RED, 16'hFFFF);
    queue_sample(6'd20, 16'd12345, 1'b0);
    queue_sample(6'd21, 16'hFFFF, 1'b0);
    queue_sample(6'd23, 16'd0, 1'b1);
    drain();

    // Alpha exactly one, widest threshold, zero red level
    write_reg(REG_ALPHA, CFG_DATA_W'(UNITY));
    write_reg(REG_THRESH, 16'hFFFF);
    write_reg(REG_YELLOW, 16'hFFFF);
    write_reg(REG_RED, 16'd0);
    queue_sample(6'd23, 16'hFFFF, 1'b0);
    queue_sample(6'd24, 16'd100, 1'b1);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // Fresh settings, extremes included
      case ($urandom_range(0, 5))
        0:       write_reg(REG_ALPHA, 16'd0);
        1:       write_reg(REG_ALPHA, CFG_DATA_W'(UNITY));
        2:       write_reg(REG_ALPHA, CFG_DATA_W'($urandom_range(UNITY + 1, 16'hFFFF)));
        default: write_reg(REG_ALPHA, CFG_DATA_W'($urandom_range(1, UNITY - 1)));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(REG_THRESH, 16'd0);
        1:       write_reg(REG_THRESH, 16'hFFFF);
        default: write_reg(REG_THRESH, CFG_DATA_W'($urandom_range(0, 3000)));
      endcase
      case ($urandom_range(0, 4))
        0: begin
          yl = RATIO_W'($urandom_range(0, 40000));
          rl = RATIO_W'($urandom_range(0, 32'(yl)));
        end
        1: begin
          yl = $urandom_range(0, 1) ? 16'd0 : 16'hFFFF;
          rl = $urandom_range(0, 1) ? 16'd0 : 16'hFFFF;
        end
        default: begin
          yl = RATIO_W'($urandom_range(0, 20000));
          rl = RATIO_W'(32'(yl) + $urandom_range(0, 20000));
        end
      endcase
      write_reg(REG_YELLOW, yl);
      write_reg(REG_RED, rl);
      if ($urandom_range(0, 1))
        write_reg(CFG_IDX_W'($urandom_range(32'(REG_SPARE_LO), 2 ** CFG_IDX_W - 1)),
                  CFG_DATA_W'($urandom_range(0, 16'hFFFF)));

      sender_idles = ($urandom_range(0, 3) != 0);
      sink_stalls  = ($urandom_range(0, 3) != 0);

      // Narrow channel windows hammer the same entry back to back
      ch_base = CH_W'($urandom_range(0, CHANNELS - 1));
      case ($urandom_range(0, 2))
        0:       ch_span = 1;
        1:       ch_span = 4;
        default: ch_span = CHANNELS;
      endcase

      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        ch = CH_W'(32'(ch_base) + $urandom_range(0, ch_span - 1));
        case ($urandom_range(0, 9))
          0:       raw = 16'd0;
          1:       raw = 16'hFFFF;
          2:       raw = RATIO_W'(32'(yl) + $urandom_range(0, 4) - 2);
          3:       raw = RATIO_W'(32'(rl) + $urandom_range(0, 4) - 2);
          4:       raw = RATIO_W'(32'(ema_value[ch]) + 32'(cfg_thresh) +
                                  $urandom_range(0, 4) - 2);
          5:       raw = RATIO_W'(32'(ema_value[ch]) - 32'(cfg_thresh) +
                                  $urandom_range(0, 4) - 2);
          default: raw = RATIO_W'($urandom_range(0, 16'hFFFF));
        endcase
        queue_sample(ch, raw, $urandom_range(0, 7) == 0);
      end
      drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never returned", pending_results.size(), 0);

    $display("Covered %0d samples in %0d setting phases with %0d register writes,",
             samples_sent, RANDOM_PHASES + 4, cfg_writes);
    $display("%0d results checked, %0d long output holds, %0d mismatches",
             results_checked, long_holds, mismatches);
    if (mismatches == 0) begin
      $display("per_channel_ema_severity verification clean");
    end else begin
      $display("per_channel_ema_severity verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pces_pkg.sv
hw/rtl/pces_front.sv
hw/rtl/pces_back.sv
hw/rtl/per_channel_ema_severity.sv
hw/rtl/pces_checker.sv
test/per_channel_ema_severity_tb.sv
